>>> design/psf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg
// Types, constants and small lookup functions shared by the parallax
// starfield point generator and its checker.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int STORE_PER_LAYER_DEF = 256;
  localparam int MAX_SCREEN_DEF      = 4096;
  localparam int TILE_SIZE           = 1024;
  localparam int TILE_W              = $clog2(TILE_SIZE);
  localparam int LAYER_COUNT         = 3;
  localparam int RESULT_CAP          = 16;
  localparam int CNT_W               = $clog2(RESULT_CAP);
  localparam int SCREEN_IN_W         = 13;
  localparam int POINT_W             = 12;
  localparam int DRAW_W              = 15;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLASSIC = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STAR_ON = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DENSITY = 2'd2;

  localparam logic [1:0] LAYER_FAR  = 2'd0;
  localparam logic [1:0] LAYER_MID  = 2'd1;
  localparam logic [1:0] LAYER_NEAR = 2'd2;

  localparam logic [31:0] LCG_A    = 32'd1103515245;
  localparam logic [31:0] LCG_C    = 32'd12345;
  localparam logic [31:0] LCG_SEED = 32'h5eed1234;

  localparam logic [7:0] LEVEL_BASE = 8'd120;

  // floor(v / 136) = (v * DIV136_MUL) >> DIV136_SHIFT for 15-bit v
  localparam logic [14:0] DIV136_MUL   = 15'd30841;
  localparam int          DIV136_SHIFT = 22;
  // floor(v / 100) = (v * DIV100_MUL) >> DIV100_SHIFT for v below 2^17
  localparam logic [17:0] DIV100_MUL   = 18'd167773;
  localparam int          DIV100_SHIFT = 24;

  typedef struct packed {
    logic signed [31:0]       view_x;
    logic signed [31:0]       view_y;
    logic [SCREEN_IN_W-1:0]   screen_w;
    logic [SCREEN_IN_W-1:0]   screen_h;
    logic [1:0]               layer;
    logic [7:0]               star_index;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic [7:0]         alpha;
    logic               last;
  } out_item_t;

  // Q0.16 parallax factors 0.15, 0.35, 0.60
  function automatic logic [16:0] scroll_factor(input logic [1:0] layer);
    logic [16:0] f;
    case (layer)
      LAYER_FAR:  f = 17'd9830;
      LAYER_MID:  f = 17'd22938;
      LAYER_NEAR: f = 17'd39322;
      default:    f = 17'd0;
    endcase
    return f;
  endfunction

  // alpha = (level * alpha_mul) >> shift gives 2/5, 13/20 and 1 exactly
  function automatic logic [16:0] alpha_mul(input logic [1:0] layer);
    logic [16:0] m;
    case (layer)
      LAYER_FAR:  m = 17'd410;
      LAYER_MID:  m = 17'd42601;
      LAYER_NEAR: m = 17'd1;
      default:    m = 17'd0;
    endcase
    return m;
  endfunction

endpackage

>>> design/parallax_starfield_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallax_starfield_point_generator
// Fills a three-layer star store once from an LCG, then turns each star
// request into the screen points of every visible tile copy of that star.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | payload
//  cfg_       | in        | cfg_we             | cfg_addr, cfg_wdata
//  in_        | in        | in_valid, in_stall | in_data  (in_item_t)
//  out_       | out       | out_valid, out_stall | out_data (out_item_t)
//
//  One shared 33x33 multiplier under a sequencer does all multiplication.
//  Store fill, once on the first enabled item: S_N0-S_N2, then per star
//  S_F_MUL/S_F_UPD for x, y and level, S_F_MOD and S_F_WR (345 stars at
//  default density 45%). After the fill: S_CHK, S_SX, S_SY, S_AL, then
//  S_EMIT per result (up to 16). Synchronous active-low reset; store
//  contents are not cleared. A stalled output stalls S_EMIT and S_INV.
// ----------------------------------------------------------------------------
module parallax_starfield_point_generator #(
  parameter int STORE_PER_LAYER = psf_pkg::STORE_PER_LAYER_DEF,
  parameter int MAX_SCREEN      = psf_pkg::MAX_SCREEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [psf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  psf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output psf_pkg::out_item_t              out_data
);
  import psf_pkg::*;

  localparam int NW  = $clog2(STORE_PER_LAYER + 1);
  localparam int AW  = $clog2(LAYER_COUNT * STORE_PER_LAYER);
  localparam int SW  = $clog2(MAX_SCREEN + 1);
  localparam int CW  = ((SW > SCREEN_IN_W) ? SW : SCREEN_IN_W) + 1;
  localparam int VW  = NW + CFG_DATA_W;
  localparam int IXW = (NW > 8) ? NW : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_N0    = 4'd1;
  localparam logic [3:0] S_N1    = 4'd2;
  localparam logic [3:0] S_N2    = 4'd3;
  localparam logic [3:0] S_F_MUL = 4'd4;
  localparam logic [3:0] S_F_UPD = 4'd5;
  localparam logic [3:0] S_F_MOD = 4'd6;
  localparam logic [3:0] S_F_WR  = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_SX    = 4'd9;
  localparam logic [3:0] S_SY    = 4'd10;
  localparam logic [3:0] S_AL    = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;
  localparam logic [3:0] S_INV   = 4'd13;

  localparam logic [1:0] FIELD_X     = 2'd0;
  localparam logic [1:0] FIELD_Y     = 2'd1;
  localparam logic [1:0] FIELD_LEVEL = 2'd2;

  logic [3:0]            state_r, state_nxt;
  logic                  classic_r, classic_nxt;
  logic                  star_on_r, star_on_nxt;
  logic [CFG_DATA_W-1:0] density_r, density_nxt;
  logic                  filled_r, filled_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic                  out_valid_r, out_valid_nxt;

  in_item_t              in_r, in_nxt;
  out_item_t             out_r, out_nxt;
  logic [31:0]           s_r, s_nxt;
  logic [1:0]            l_r, l_nxt;
  logic [NW-1:0]         i_r, i_nxt;
  logic [1:0]            field_r, field_nxt;
  logic [DRAW_W-1:0]     draw_r, draw_nxt;
  logic [TILE_W-1:0]     sx_r, sx_nxt;
  logic [TILE_W-1:0]     bx_r, bx_nxt;
  logic [TILE_W-1:0]     by_r, by_nxt;
  logic [7:0]            alpha_r, alpha_nxt;
  logic [CW-1:0]         tx_r, tx_nxt;
  logic [CW-1:0]         ty_r, ty_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [65:0]    prod_r;

  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;

  logic                  ram_we_x, ram_we_y, ram_we_l, ram_re;
  logic [AW-1:0]         ram_addr, layer_base;
  logic [1:0]            sel_layer;
  logic [TILE_W-1:0]     xq, yq;
  logic [7:0]            lq;

  logic                  out_free;
  logic [31:0]           s_upd;
  logic [DRAW_W-1:0]     draw_w;
  logic [7:0]            q136;
  logic [DRAW_W-1:0]     rem136;
  logic [7:0]            level_w;
  logic [VW-1:0]         q100;
  logic [47:0]           mag_w;
  logic [TILE_W-1:0]     shift_w;
  logic [CW-1:0]         w_sat, h_sat, w_ext, h_ext;
  logic [CW-1:0]         nx_w, ny_w;
  logic                  nx_ok, ny_ok, last_w;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign w_ext = CW'(in_r.screen_w);
  assign h_ext = CW'(in_r.screen_h);
  assign w_sat = (w_ext > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : w_ext;
  assign h_sat = (h_ext > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : h_ext;

  assign s_upd   = prod_r[31:0] + LCG_C;
  assign draw_w  = s_upd[30:16];
  assign q136    = prod_r[DIV136_SHIFT +: 8];
  assign rem136  = draw_r - (DRAW_W'(q136) << 7) - (DRAW_W'(q136) << 3);
  assign level_w = LEVEL_BASE + rem136[7:0];
  assign q100    = prod_r[DIV100_SHIFT +: VW];

  assign mag_w   = prod_r[65] ? (48'd0 - prod_r[47:0]) : prod_r[47:0];
  assign shift_w = prod_r[65] ? ({TILE_W{1'b0}} - mag_w[24 +: TILE_W])
                              : mag_w[24 +: TILE_W];

  assign nx_w   = tx_r + CW'(TILE_SIZE);
  assign ny_w   = ty_r + CW'(TILE_SIZE);
  assign nx_ok  = nx_w < w_sat;
  assign ny_ok  = ny_w < h_sat;
  assign last_w = (cnt_r == CNT_W'(RESULT_CAP - 1)) || (!nx_ok && !ny_ok);

  assign sel_layer = (state_r == S_CHK) ? in_r.layer : l_r;

  always_comb begin
    case (sel_layer)
      LAYER_FAR: layer_base = '0;
      LAYER_MID: layer_base = AW'(STORE_PER_LAYER);
      default:   layer_base = AW'(2 * STORE_PER_LAYER);
    endcase
  end

  assign ram_addr = layer_base + ((state_r == S_CHK) ? AW'(in_r.star_index) : AW'(i_r));
  assign ram_we_x = (state_r == S_F_UPD) && (field_r == FIELD_X);
  assign ram_we_y = (state_r == S_F_UPD) && (field_r == FIELD_Y);
  assign ram_we_l = (state_r == S_F_WR);
  assign ram_re   = (state_r == S_CHK);

  psf_ram #(.WIDTH(TILE_W), .DEPTH(LAYER_COUNT * STORE_PER_LAYER)) u_ram_x (
    .clk(clk), .we(ram_we_x), .re(ram_re), .addr(ram_addr),
    .wdata(draw_w[TILE_W-1:0]), .rdata(xq)
  );

  psf_ram #(.WIDTH(TILE_W), .DEPTH(LAYER_COUNT * STORE_PER_LAYER)) u_ram_y (
    .clk(clk), .we(ram_we_y), .re(ram_re), .addr(ram_addr),
    .wdata(draw_w[TILE_W-1:0]), .rdata(yq)
  );

  psf_ram #(.WIDTH(8), .DEPTH(LAYER_COUNT * STORE_PER_LAYER)) u_ram_l (
    .clk(clk), .we(ram_we_l), .re(ram_re), .addr(ram_addr),
    .wdata(level_w), .rdata(lq)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_N0: begin
        mul_a = 33'(STORE_PER_LAYER);
        mul_b = 33'(density_r);
      end
      S_N1: begin
        mul_a = 33'(prod_r[VW-1:0]);
        mul_b = 33'(DIV100_MUL);
      end
      S_F_MUL: begin
        mul_a = {1'b0, s_r};
        mul_b = {1'b0, LCG_A};
      end
      S_F_MOD: begin
        mul_a = 33'(draw_r);
        mul_b = 33'(DIV136_MUL);
      end
      S_CHK: begin
        mul_a = {in_r.view_x[31], in_r.view_x};
        mul_b = 33'(scroll_factor(in_r.layer));
      end
      S_SX: begin
        mul_a = {in_r.view_y[31], in_r.view_y};
        mul_b = 33'(scroll_factor(in_r.layer));
      end
      S_SY: begin
        mul_a = 33'(lq);
        mul_b = 33'(alpha_mul(in_r.layer));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    classic_nxt   = classic_r;
    star_on_nxt   = star_on_r;
    density_nxt   = density_r;
    filled_nxt    = filled_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_nxt        = in_r;
    out_nxt       = out_r;
    s_nxt         = s_r;
    l_nxt         = l_r;
    i_nxt         = i_r;
    field_nxt     = field_r;
    draw_nxt      = draw_r;
    sx_nxt        = sx_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    alpha_nxt     = alpha_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    cnt_nxt       = cnt_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_CLASSIC: classic_nxt = cfg_wdata[0];
        CFG_STAR_ON: star_on_nxt = cfg_wdata[0];
        CFG_DENSITY: density_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          if (classic_r || !star_on_r) begin
            state_nxt = S_INV;
          end else if (!filled_r) begin
            state_nxt = S_N0;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_N0: state_nxt = S_N1;
      S_N1: state_nxt = S_N2;
      S_N2: begin
        n_nxt     = (q100 > VW'(STORE_PER_LAYER)) ? NW'(STORE_PER_LAYER) : q100[NW-1:0];
        s_nxt     = LCG_SEED;
        l_nxt     = LAYER_FAR;
        i_nxt     = '0;
        field_nxt = FIELD_X;
        if (n_nxt == '0) begin
          filled_nxt = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          state_nxt = S_F_MUL;
        end
      end
      S_F_MUL: state_nxt = S_F_UPD;
      S_F_UPD: begin
        s_nxt = s_upd;
        case (field_r)
          FIELD_X: begin
            field_nxt = FIELD_Y;
            state_nxt = S_F_MUL;
          end
          FIELD_Y: begin
            field_nxt = FIELD_LEVEL;
            state_nxt = S_F_MUL;
          end
          default: begin
            draw_nxt  = draw_w;
            state_nxt = S_F_MOD;
          end
        endcase
      end
      S_F_MOD: state_nxt = S_F_WR;
      S_F_WR: begin
        field_nxt = FIELD_X;
        state_nxt = S_F_MUL;
        if (i_r == NW'(n_r - 1'b1)) begin
          i_nxt = '0;
          if (l_r == LAYER_NEAR) begin
            filled_nxt = 1'b1;
            state_nxt  = S_CHK;
          end else begin
            l_nxt = l_r + 2'd1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_CHK: begin
        if (in_r.layer > LAYER_NEAR || IXW'(in_r.star_index) >= IXW'(n_r)) begin
          state_nxt = S_INV;
        end else begin
          state_nxt = S_SX;
        end
      end
      S_SX: begin
        sx_nxt    = shift_w;
        state_nxt = S_SY;
      end
      S_SY: begin
        bx_nxt    = xq - sx_r;
        by_nxt    = yq - shift_w;
        state_nxt = S_AL;
      end
      S_AL: begin
        case (in_r.layer)
          LAYER_FAR: alpha_nxt = prod_r[17:10];
          LAYER_MID: alpha_nxt = prod_r[23:16];
          default:   alpha_nxt = prod_r[7:0];
        endcase
        tx_nxt  = CW'(bx_r);
        ty_nxt  = CW'(by_r);
        cnt_nxt = '0;
        if (CW'(by_r) < h_sat && CW'(bx_r) < w_sat) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_INV;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.visible = 1'b1;
          out_nxt.point_x = tx_r[POINT_W-1:0];
          out_nxt.point_y = ty_r[POINT_W-1:0];
          out_nxt.alpha   = alpha_r;
          out_nxt.last    = last_w;
          cnt_nxt         = cnt_r + 1'b1;
          if (last_w) begin
            state_nxt = S_IDLE;
          end else if (nx_ok) begin
            tx_nxt = nx_w;
          end else begin
            tx_nxt = CW'(bx_r);
            ty_nxt = ny_w;
          end
        end
      end
      S_INV: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.visible = 1'b0;
          out_nxt.point_x = '0;
          out_nxt.point_y = '0;
          out_nxt.alpha   = '0;
          out_nxt.last    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      classic_r   <= 1'b0;
      star_on_r   <= 1'b1;
      density_r   <= CFG_DATA_W'(45);
      filled_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      classic_r   <= classic_nxt;
      star_on_r   <= star_on_nxt;
      density_r   <= density_nxt;
      filled_r    <= filled_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    out_r   <= out_nxt;
    s_r     <= s_nxt;
    l_r     <= l_nxt;
    i_r     <= i_nxt;
    field_r <= field_nxt;
    draw_r  <= draw_nxt;
    sx_r    <= sx_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    alpha_r <= alpha_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= mul_a * mul_b;
  end

endmodule

>>> design/psf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_ram
// Single-port RAM with registered read data; read data holds between reads.
// ----------------------------------------------------------------------------
module psf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/psf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks on the parallax starfield point generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module psf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input psf_pkg::out_item_t out_data
);
  import psf_pkg::*;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall
  ) else $error("input taken again right after an accepted item");

  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)
  ) else $error("stalled result item changed");

  a_invisible_form: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |->
      out_data.last && out_data.point_x == '0 && out_data.point_y == '0 &&
      out_data.alpha == '0
  ) else $error("invisible item with nonzero fields or without last");

  a_idle_only_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_stall && out_valid |-> out_data.last
  ) else $error("ready for input while results of an item are pending");

endmodule

bind parallax_starfield_point_generator psf_checker u_psf_checker (.*);

>>> dv/parallax_starfield_point_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallax_starfield_point_generator_tb
// Self-checking bench for the starfield point generator. A local model keeps
// its own copy of the star store, fills it from the same LCG on the first
// enabled request and predicts every tile-copy point of each request. The
// input idles and the output stalls at random, the output is held off once
// for a long stretch, and the configuration moves through disabled, enabled
// and post-fill density settings.
// ----------------------------------------------------------------------------
module parallax_starfield_point_generator_tb;
  import psf_pkg::*;

  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          STORE_DEPTH    = LAYER_COUNT * STORE_PER_LAYER_DEF;
  localparam logic [1:0]  LAYER_NONE     = 2'd3;
  localparam out_item_t   NO_POINT       = '{visible: 1'b0, point_x: '0, point_y: '0,
                                             alpha: '0, last: 1'b1};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  parallax_starfield_point_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  bit           sky_classic = 1'b0;
  bit           sky_on      = 1'b1;
  bit [6:0]     sky_density = 7'd45;
  bit [9:0]     sky_x [STORE_DEPTH];
  bit [9:0]     sky_y [STORE_DEPTH];
  bit [7:0]     sky_level [STORE_DEPTH];
  int unsigned  stars_per_layer_m = 0;
  bit           sky_filled = 1'b0;

  out_item_t    expected_points [$];
  int           errors = 0;
  int           n_requests = 0;
  int           n_points = 0;
  int           n_visible = 0;
  int           fill_pct;
  bit           quiet = 1'b0;
  int           hold_ask = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           idle_cycles = 0;

  function automatic void fill_sky();
    bit [31:0]   seed;
    int unsigned n;
    int unsigned a;
    seed = LCG_SEED;
    n = (STORE_PER_LAYER_DEF * sky_density) / 100;
    if (n > STORE_PER_LAYER_DEF) n = STORE_PER_LAYER_DEF;
    stars_per_layer_m = n;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      for (int i = 0; i < n; i++) begin
        a = l * STORE_PER_LAYER_DEF + i;
        seed = seed * LCG_A + LCG_C;
        sky_x[a] = seed[25:16];
        seed = seed * LCG_A + LCG_C;
        sky_y[a] = seed[25:16];
        seed = seed * LCG_A + LCG_C;
        sky_level[a] = LEVEL_BASE + 8'(seed[30:16] % 136);
      end
    end
    sky_filled = 1'b1;
  endfunction

  function automatic int unsigned layer_scroll(input logic [1:0] lyr);
    case (lyr)
      LAYER_FAR:  return 9830;
      LAYER_MID:  return 22938;
      default:    return 39322;
    endcase
  endfunction

  function automatic int unsigned layer_alpha(input logic [1:0] lyr, input int unsigned lvl);
    case (lyr)
      LAYER_FAR:  return (lvl * 2) / 5;
      LAYER_MID:  return (lvl * 13) / 20;
      default:    return lvl;
    endcase
  endfunction

  // trunc(view * factor / 2^24) toward zero, wrapped into the tile
  function automatic int unsigned tile_shift(input logic signed [31:0] view,
                                             input int unsigned factor);
    longint      p;
    longint      mag;
    int unsigned r;
    p = longint'(view) * longint'(factor);
    mag = (p < 0) ? -p : p;
    r = 32'((mag >> 24) % TILE_SIZE);
    if (p < 0 && r != 0) r = TILE_SIZE - r;
    return r;
  endfunction

  function automatic void predict_points(input in_item_t it);
    int unsigned w, h, a, sx, sy, bx, by, al;
    out_item_t   pts [$];
    out_item_t   pt;
    if (sky_classic || !sky_on) begin
      expected_points.push_back(NO_POINT);
      return;
    end
    if (!sky_filled) fill_sky();
    w = (it.screen_w > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : it.screen_w;
    h = (it.screen_h > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : it.screen_h;
    if (it.layer >= LAYER_COUNT || it.star_index >= stars_per_layer_m) begin
      expected_points.push_back(NO_POINT);
      return;
    end
    a  = it.layer * STORE_PER_LAYER_DEF + it.star_index;
    sx = tile_shift(it.view_x, layer_scroll(it.layer));
    sy = tile_shift(it.view_y, layer_scroll(it.layer));
    bx = (sky_x[a] >= sx) ? sky_x[a] - sx : sky_x[a] + TILE_SIZE - sx;
    by = (sky_y[a] >= sy) ? sky_y[a] - sy : sky_y[a] + TILE_SIZE - sy;
    al = layer_alpha(it.layer, 32'(sky_level[a]));
    for (int unsigned ty = by; ty < h && pts.size() < RESULT_CAP; ty += TILE_SIZE) begin
      for (int unsigned tx = bx; tx < w && pts.size() < RESULT_CAP; tx += TILE_SIZE) begin
        pt.visible = 1'b1;
        pt.point_x = tx[POINT_W-1:0];
        pt.point_y = ty[POINT_W-1:0];
        pt.alpha   = al[7:0];
        pt.last    = 1'b0;
        pts.push_back(pt);
      end
    end
    if (pts.size() == 0) begin
      expected_points.push_back(NO_POINT);
      return;
    end
    pts[pts.size()-1].last = 1'b1;
    foreach (pts[i]) expected_points.push_back(pts[i]);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (point %0d)", what, got, want, n_points);
    errors++;
  endtask

  task automatic check_point(input out_item_t got);
    out_item_t want;
    if (expected_points.size() == 0) begin
      report("unexpected point", int'(got.visible), 0);
      return;
    end
    want = expected_points.pop_front();
    if (got.visible !== want.visible)
      report("visible", int'(got.visible), int'(want.visible));
    if (got.point_x !== want.point_x)
      report("point_x", int'(got.point_x), int'(want.point_x));
    if (got.point_y !== want.point_y)
      report("point_y", int'(got.point_y), int'(want.point_y));
    if (got.alpha   !== want.alpha)
      report("alpha",   int'(got.alpha),   int'(want.alpha));
    if (got.last    !== want.last)
      report("last",    int'(got.last),    int'(want.last));
    n_points++;
    if (want.visible) n_visible++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_point(out_data);
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d points still expected", expected_points.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_star(input in_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_points(it);
    n_requests++;
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input bit classic, input bit on, input int density);
    drain_points();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CLASSIC;
    cfg_wdata <= CFG_DATA_W'(classic);
    @(posedge clk);
    cfg_addr  <= CFG_STAR_ON;
    cfg_wdata <= CFG_DATA_W'(on);
    @(posedge clk);
    cfg_addr  <= CFG_DENSITY;
    cfg_wdata <= CFG_DATA_W'(density);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sky_classic = classic;
    sky_on      = on;
    sky_density = 7'(density);
  endtask

  function automatic in_item_t make_star(input logic signed [31:0] vx, input logic signed [31:0] vy,
                                         input logic [12:0] w, input logic [12:0] h,
                                         input logic [1:0] lyr, input logic [7:0] idx);
    in_item_t it;
    it.view_x     = vx;
    it.view_y     = vy;
    it.screen_w   = w;
    it.screen_h   = h;
    it.layer      = lyr;
    it.star_index = idx;
    return it;
  endfunction

  function automatic logic signed [31:0] random_view();
    case ($urandom_range(7))
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2:       return int'($urandom_range(2047)) - 1024;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [12:0] random_extent();
    case ($urandom_range(7))
      0:       return 13'($urandom_range(63));
      1:       return 13'($urandom_range(8191, 4097));
      2:       return 13'd4096;
      3:       return 13'($urandom_range(1100, 900));
      default: return 13'($urandom_range(4096));
    endcase
  endfunction

  function automatic in_item_t random_star();
    logic [1:0] lyr;
    logic [7:0] idx;
    lyr = ($urandom_range(9) == 0) ? LAYER_NONE : 2'($urandom_range(2));
    if (stars_per_layer_m != 0 && $urandom_range(9) < 8) begin
      idx = 8'($urandom_range(stars_per_layer_m - 1));
    end else begin
      idx = 8'($urandom_range(255));
    end
    return make_star(random_view(), random_view(), random_extent(), random_extent(), lyr, idx);
  endfunction

  task automatic test_disabled_modes();
    apply_settings(1'b1, 1'b1, 0);
    repeat (3) send_star(random_star());
    apply_settings(1'b0, 1'b0, 100);
    repeat (3) send_star(random_star());
    apply_settings(1'b1, 1'b0, fill_pct);
    repeat (2) send_star(random_star());
    apply_settings(1'b0, 1'b1, fill_pct);
  endtask

  task automatic test_directed_stars();
    int unsigned top;
    // the first enabled request fills the store even for a bad layer
    send_star(make_star(0, 0, 1024, 768, LAYER_NONE, 0));
    top = stars_per_layer_m;
    send_star(make_star(0, 0, 4096, 4096, LAYER_FAR, 0));
    send_star(make_star(32'sh7fffffff, 32'sh7fffffff, 8191, 8191, LAYER_MID, 8'(top - 1)));
    send_star(make_star(32'sh80000000, 32'sh80000000, 4096, 4096, LAYER_NEAR, 0));
    send_star(make_star(32'sh80000000, 32'sh7fffffff, 4095, 4095, LAYER_FAR, 8'(top - 1)));
    send_star(make_star(0, 0, 4096, 4096, LAYER_FAR, 8'(top)));
    send_star(make_star(0, 0, 4096, 4096, LAYER_NEAR, 255));
    send_star(make_star(0, 0, 0, 0, LAYER_MID, 1));
    send_star(make_star(0, 0, 0, 4096, LAYER_NEAR, 2));
    send_star(make_star(0, 0, 1, 1, LAYER_FAR, 3));
    send_star(make_star(-1, -1, 2048, 2048, LAYER_NEAR, 4));
    send_star(make_star(-256, 256, 1024, 1024, LAYER_NEAR, 5));
    send_star(make_star(32'sh00040000, -32'sh00040000, 3000, 1500, LAYER_MID, 6));
    send_star(make_star(12345678, -87654321, 1024, 1, LAYER_FAR, 7));
    send_star(make_star(-12345678, 87654321, 1, 1024, LAYER_MID, 8));
    send_star(make_star(32'sh55555555, 32'shaaaaaaaa, 8191, 0, LAYER_NEAR, 9));
    send_star(make_star(32'shaaaaaaaa, 32'sh55555555, 6000, 2500, LAYER_NONE, 255));
  endtask

  task automatic test_density_after_fill();
    apply_settings(1'b0, 1'b1, 0);
    repeat (4) send_star(random_star());
    apply_settings(1'b0, 1'b1, 100);
    repeat (4) send_star(random_star());
    apply_settings(1'b1, 1'b0, 45);
    repeat (4) send_star(random_star());
    apply_settings(1'b0, 1'b1, fill_pct);
  endtask

  task automatic test_output_hold();
    drain_points();
    hold_ask++;
    repeat (30) begin
      send_star(make_star(random_view(), random_view(), 4096, 4096,
                          2'($urandom_range(2)), 8'($urandom_range(stars_per_layer_m - 1))));
    end
    drain_points();
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 6; chunk++) begin
      if (chunk == 0 || chunk == 3) begin
        apply_settings(1'b0, 1'b1, $urandom_range(100));
      end else begin
        apply_settings($urandom_range(5) == 0, $urandom_range(5) != 0, $urandom_range(100));
      end
      quiet = (chunk == 3);
      repeat (40) send_star(random_star());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_CLASSIC;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    fill_pct = $urandom_range(95, 55);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_modes();
    test_directed_stars();
    test_density_after_fill();
    test_output_hold();
    test_random_traffic();

    drain_points();
    repeat (20) @(posedge clk);
    $display("covered %0d star requests, %0d results checked (%0d visible points)",
             n_requests, n_points, n_visible);
    $display("store filled at %0d%% density: %0d stars per layer", fill_pct, stars_per_layer_m);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
